// File: rtl/lts_pkg.sv
// shared types, constants and the keyword table of the lexical token scanner
// no dependencies
package lts_pkg;

  localparam int POS_BITS  = 16;
  localparam int KW_CHARS  = 6;
  localparam int N_KW      = 16;
  localparam int Q_DEPTH   = 8;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int WCNT_BITS = $clog2(KW_CHARS + 1);

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_STAR    = 6'd9;
  localparam logic [5:0] K_BANG    = 6'd10;
  localparam logic [5:0] K_BANG_EQ = 6'd11;
  localparam logic [5:0] K_EQUAL   = 6'd12;
  localparam logic [5:0] K_EQ_EQ   = 6'd13;
  localparam logic [5:0] K_LESS    = 6'd14;
  localparam logic [5:0] K_LESS_EQ = 6'd15;
  localparam logic [5:0] K_GREATER = 6'd16;
  localparam logic [5:0] K_GREAT_EQ = 6'd17;
  localparam logic [5:0] K_SLASH   = 6'd18;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_NUMBER  = 6'd20;
  localparam logic [5:0] K_KW0     = 6'd21;
  localparam logic [5:0] K_EOF     = 6'd37;
  localparam logic [5:0] K_ERROR   = 6'd38;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_BANG    = 4'd1,
    PH_EQUAL   = 4'd2,
    PH_LESS    = 4'd3,
    PH_GREATER = 4'd4,
    PH_SLASH   = 4'd5,
    PH_COMMENT = 4'd6,
    PH_IDENT   = 4'd7,
    PH_INT     = 4'd8,
    PH_DOT     = 4'd9,
    PH_FRAC    = 4'd10
  } phase_t;

  typedef struct packed {
    logic [15:0] line;
    logic [15:0] len;
    logic [15:0] start;
    logic [5:0]  kind;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0]       n;
    token_t [2:0]     tok;
  } push_t;

  typedef logic [KW_CHARS-1:0][7:0] word_t;

  localparam logic [POS_BITS:0] OUT_MAX = (POS_BITS+1)'(17'h0FFFF);

  // keyword text, first character in byte 0, zero padded
  function automatic word_t kw_word(input logic [3:0] k);
    logic [KW_CHARS*8-1:0] s;
    word_t w;
    int n;
    s = '0;
    w = '0;
    n = 0;
    unique case (k)
      4'd0:  s = (KW_CHARS*8)'("and");
      4'd1:  s = (KW_CHARS*8)'("class");
      4'd2:  s = (KW_CHARS*8)'("else");
      4'd3:  s = (KW_CHARS*8)'("false");
      4'd4:  s = (KW_CHARS*8)'("for");
      4'd5:  s = (KW_CHARS*8)'("fun");
      4'd6:  s = (KW_CHARS*8)'("if");
      4'd7:  s = (KW_CHARS*8)'("nil");
      4'd8:  s = (KW_CHARS*8)'("or");
      4'd9:  s = (KW_CHARS*8)'("print");
      4'd10: s = (KW_CHARS*8)'("return");
      4'd11: s = (KW_CHARS*8)'("super");
      4'd12: s = (KW_CHARS*8)'("this");
      4'd13: s = (KW_CHARS*8)'("true");
      4'd14: s = (KW_CHARS*8)'("var");
      4'd15: s = (KW_CHARS*8)'("while");
      default: s = '0;
    endcase
    for (int i = 0; i < KW_CHARS; i++) begin
      if (s[8*i +: 8] != 8'd0) n = i + 1;
    end
    for (int i = 0; i < KW_CHARS; i++) begin
      if (i < n) w[i] = s[8*(n-1-i) +: 8];
    end
    return w;
  endfunction

  // build a result from offsets, clamping start and length
  function automatic token_t mk_tok(input logic [5:0] kind,
                                    input logic [POS_BITS:0] st,
                                    input logic [POS_BITS:0] en,
                                    input logic [15:0] line);
    token_t t;
    logic [POS_BITS:0] len;
    len = (en > st) ? (en - st) : '0;
    t.kind  = kind;
    t.start = 16'((st > OUT_MAX) ? OUT_MAX : st);
    t.len   = 16'((len > OUT_MAX) ? OUT_MAX : len);
    t.line  = line;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

// File: rtl/lts_core.sv
// scanner state and the single-pass token logic for one byte per cycle while step is high
// depends on lts_pkg
module lts_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     char_byte,
  input  logic           end_of_input,
  output lts_pkg::push_t push
);
  import lts_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [POS_BITS-1:0]     lstart_r, lstart_nxt;
  logic [POS_BITS-1:0]     pos_r, pos_nxt;
  logic [15:0]             line_r, line_nxt;
  word_t                   wbuf_r, wbuf_nxt;
  logic [WCNT_BITS-1:0]    wcnt_r, wcnt_nxt;
  logic                    wovf_r, wovf_nxt;

  logic [POS_BITS:0] cur, cur1, ls, ls1, dpos, dpos1;
  logic is_dig, is_alp;

  // start-of-lexeme decode
  phase_t     sc_phase;
  logic       sc_emit, sc_nl, sc_id;
  logic [5:0] sc_kind;

  token_t fa, fb, xt;
  logic   fa_v, fb_v, x_v, fl, st;
  logic [5:0] wkind;

  assign cur    = {1'b0, pos_r};
  assign cur1   = cur + 1'b1;
  assign ls     = {1'b0, lstart_r};
  assign ls1    = ls + 1'b1;
  assign dpos   = (cur != '0) ? cur - 1'b1 : '0;
  assign dpos1  = dpos + 1'b1;
  assign is_dig = (char_byte >= "0") && (char_byte <= "9");
  assign is_alp = ((char_byte >= "a") && (char_byte <= "z")) ||
                  ((char_byte >= "A") && (char_byte <= "Z")) || (char_byte == "_");

  always_comb begin
    wkind = K_IDENT;
    if (!wovf_r) begin
      for (int k = 0; k < N_KW; k++) begin
        if (wbuf_r == kw_word(4'(k))) wkind = K_KW0 + 6'(k);
      end
    end
  end

  always_comb begin
    sc_phase = PH_IDLE;
    sc_emit  = 1'b0;
    sc_nl    = 1'b0;
    sc_id    = 1'b0;
    sc_kind  = K_ERROR;
    unique case (char_byte)
      "(": begin sc_emit = 1'b1; sc_kind = K_LPAREN; end
      ")": begin sc_emit = 1'b1; sc_kind = K_RPAREN; end
      "{": begin sc_emit = 1'b1; sc_kind = K_LBRACE; end
      "}": begin sc_emit = 1'b1; sc_kind = K_RBRACE; end
      ",": begin sc_emit = 1'b1; sc_kind = K_COMMA; end
      ".": begin sc_emit = 1'b1; sc_kind = K_DOT; end
      "-": begin sc_emit = 1'b1; sc_kind = K_MINUS; end
      "+": begin sc_emit = 1'b1; sc_kind = K_PLUS; end
      ";": begin sc_emit = 1'b1; sc_kind = K_SEMI; end
      "*": begin sc_emit = 1'b1; sc_kind = K_STAR; end
      "!": sc_phase = PH_BANG;
      "=": sc_phase = PH_EQUAL;
      "<": sc_phase = PH_LESS;
      ">": sc_phase = PH_GREATER;
      "/": sc_phase = PH_SLASH;
      " ", 8'h0d, 8'h09: sc_phase = PH_IDLE;
      8'h0a: sc_nl = 1'b1;
      default: begin
        if (is_dig) sc_phase = PH_INT;
        else if (is_alp) begin
          sc_phase = PH_IDENT;
          sc_id    = 1'b1;
        end else sc_emit = 1'b1;
      end
    endcase
  end

  // pending token closed at the current offset
  always_comb begin
    fa_v = 1'b0;
    fb_v = 1'b0;
    fa   = mk_tok(K_NUMBER, ls, cur, line_r);
    fb   = mk_tok(K_DOT, dpos, dpos1, line_r);
    unique case (phase_r)
      PH_BANG:    begin fa_v = 1'b1; fa = mk_tok(K_BANG, ls, ls1, line_r); end
      PH_EQUAL:   begin fa_v = 1'b1; fa = mk_tok(K_EQUAL, ls, ls1, line_r); end
      PH_LESS:    begin fa_v = 1'b1; fa = mk_tok(K_LESS, ls, ls1, line_r); end
      PH_GREATER: begin fa_v = 1'b1; fa = mk_tok(K_GREATER, ls, ls1, line_r); end
      PH_SLASH:   begin fa_v = 1'b1; fa = mk_tok(K_SLASH, ls, ls1, line_r); end
      PH_IDENT:   begin fa_v = 1'b1; fa = mk_tok(wkind, ls, cur, line_r); end
      PH_INT, PH_FRAC: fa_v = 1'b1;
      PH_DOT: begin
        fa_v = 1'b1;
        fb_v = 1'b1;
        fa   = mk_tok(K_NUMBER, ls, dpos, line_r);
      end
      default: fa_v = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    lstart_nxt = lstart_r;
    pos_nxt    = (pos_r != '1) ? pos_r + 1'b1 : pos_r;
    line_nxt   = line_r;
    wbuf_nxt   = wbuf_r;
    wcnt_nxt   = wcnt_r;
    wovf_nxt   = wovf_r;
    fl   = 1'b0;
    st   = 1'b0;
    x_v  = 1'b0;
    xt   = mk_tok(sc_kind, cur, cur1, line_r);
    if (end_of_input) begin
      fl         = 1'b1;
      x_v        = 1'b1;
      xt         = mk_tok(K_EOF, cur, cur, line_r);
      phase_nxt  = PH_IDLE;
      lstart_nxt = '0;
      pos_nxt    = '0;
      line_nxt   = 16'd1;
      wbuf_nxt   = '0;
      wcnt_nxt   = '0;
      wovf_nxt   = 1'b0;
    end else begin
      unique case (phase_r)
        PH_BANG, PH_EQUAL, PH_LESS, PH_GREATER: begin
          if (char_byte == "=") begin
            x_v       = 1'b1;
            xt        = mk_tok(fa.kind + 6'd1, ls, cur1, line_r);
            phase_nxt = PH_IDLE;
          end else begin fl = 1'b1; st = 1'b1; end
        end
        PH_SLASH: begin
          if (char_byte == "/") phase_nxt = PH_COMMENT;
          else begin fl = 1'b1; st = 1'b1; end
        end
        PH_COMMENT: st = (char_byte == 8'h0a);
        PH_IDENT: begin
          if (is_alp || is_dig) begin
            if (wcnt_r < WCNT_BITS'(KW_CHARS)) begin
              wbuf_nxt[wcnt_r[$clog2(KW_CHARS)-1:0]] = char_byte;
              wcnt_nxt = wcnt_r + 1'b1;
            end else wovf_nxt = 1'b1;
          end else begin fl = 1'b1; st = 1'b1; end
        end
        PH_INT: begin
          if (char_byte == ".") phase_nxt = PH_DOT;
          else if (!is_dig) begin fl = 1'b1; st = 1'b1; end
        end
        PH_DOT: begin
          if (is_dig) phase_nxt = PH_FRAC;
          else begin fl = 1'b1; st = 1'b1; end
        end
        PH_FRAC: begin
          if (!is_dig) begin fl = 1'b1; st = 1'b1; end
        end
        default: st = 1'b1;
      endcase
      if (fl) phase_nxt = PH_IDLE;
      if (st) begin
        phase_nxt  = sc_phase;
        lstart_nxt = pos_r;
        x_v        = sc_emit;
        if (sc_nl && line_r != 16'hFFFF) line_nxt = line_r + 1'b1;
        if (sc_id) begin
          wbuf_nxt    = '0;
          wbuf_nxt[0] = char_byte;
          wcnt_nxt    = WCNT_BITS'(1);
          wovf_nxt    = 1'b0;
        end
      end
    end
  end

  // pack results in order, last flag on the final one
  always_comb begin
    push.tok = '0;
    push.n   = 2'd0;
    if (fl && fa_v && fb_v) begin
      push.tok[0] = fa;
      push.tok[1] = fb;
      push.tok[2] = xt;
      push.n      = x_v ? 2'd3 : 2'd2;
    end else if (fl && fa_v) begin
      push.tok[0] = fa;
      push.tok[1] = xt;
      push.n      = x_v ? 2'd2 : 2'd1;
    end else begin
      push.tok[0] = xt;
      push.n      = x_v ? 2'd1 : 2'd0;
    end
    if (push.n != 2'd0) push.tok[push.n - 2'd1].last = 1'b1;
    if (!step) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      lstart_r <= '0;
      pos_r    <= '0;
      line_r   <= 16'd1;
      wbuf_r   <= '0;
      wcnt_r   <= '0;
      wovf_r   <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      lstart_r <= lstart_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      wbuf_r   <= wbuf_nxt;
      wcnt_r   <= wcnt_nxt;
      wovf_r   <= wovf_nxt;
    end
  end

endmodule

// File: rtl/lts_queue.sv
// result queue: takes up to three tokens a cycle, hands out one while deq_ready is high
// depends on lts_pkg
module lts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  lts_pkg::push_t  push,
  output logic            room,
  output logic            deq_valid,
  input  logic            deq_ready,
  output lts_pkg::token_t deq_tok
);
  import lts_pkg::*;

  token_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign deq_valid = (cnt_r != '0);
  assign deq_tok   = mem_r[rd_r];
  assign pop       = deq_valid && deq_ready;
  assign room      = (cnt_r <= (Q_AW+1)'(Q_DEPTH - 3));

  always_comb begin
    wr_nxt  = wr_r + Q_AW'(push.n);
    rd_nxt  = rd_r + Q_AW'(pop);
    cnt_nxt = cnt_r + (Q_AW+1)'(push.n) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.n) mem_r[wr_r + Q_AW'(i)] <= push.tok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/lox_token_scanner_top.sv
// top level of the lexical token scanner: scanner core and result queue
// depends on lts_pkg, lts_core, lts_queue
//
// usage
//   input stream: one source byte per transaction in in_tdata; in_tuser high
//   marks end of input, which flushes any pending token, emits an end-of-file
//   token and returns the scanner to its start state (offset 0, line 1)
//   output stream: one token per transaction; out_tlast marks the last token
//   caused by an input transaction
//   a token enters the queue when the byte that completes it is accepted and reaches out_* behind earlier tokens
//   input: one byte per cycle while in_tready is high; a byte makes zero to three tokens, and the
//   output side drains one token per cycle, while out_tready is high, from an eight-entry queue
//   in_tready is high while the queue has room for three tokens, so a burst
//   of tokens or a stalled receiver holds off the input only as the queue fills
//   a number followed by a dot is held until the next byte decides it
//   reset: synchronous, active low; empties the queue and clears all scan state
module lox_token_scanner_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tuser,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [5:0] token_kind, [21:6] token_start,
                                  // [37:22] token_length, [53:38] line_number
  output logic        out_tlast   // last_of_run
);
  import lts_pkg::*;

  push_t  push;
  token_t tok;
  logic   room, step;

  assign in_tready = room;
  assign step      = in_tvalid && room;

  lts_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .char_byte    (in_tdata),
    .end_of_input (in_tuser),
    .push         (push)
  );

  lts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .deq_valid (out_tvalid),
    .deq_ready (out_tready),
    .deq_tok   (tok)
  );

  assign out_tdata = {2'b00, tok.line, tok.len, tok.start, tok.kind};
  assign out_tlast = tok.last;

endmodule

// File: rtl/lts_checker.sv
// port-level checks on the token scanner output stream, bound to the top level
// depends on lts_pkg and lox_token_scanner_top
module lts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);
  import lts_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled transaction withdrawn");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled transaction changed");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:0] == K_EOF |-> out_tlast && out_tdata[37:22] == 16'd0)
    else $error("end-of-file token not last or not empty");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:0] <= K_ERROR && out_tdata[53:38] != 16'd0)
    else $error("token kind or line out of range");

endmodule

bind lox_token_scanner_top lts_checker u_lts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: test/lox_token_scanner_top_tb.sv
// testbench for the lexical token scanner: random and directed source bytes in,
// tokens checked against an in-bench scanner model; depends on lts_pkg and the rtl top
`timescale 1ns / 100ps

module lox_token_scanner_top_tb;
  import lts_pkg::*;

  typedef struct {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } exp_tok_t;

  class token_scoreboard;
    exp_tok_t pending[$];
    int     errors;
    phase_t phase;
    logic [15:0] lex_start;
    logic [15:0] pos;
    logic [15:0] line_cnt;
    logic [7:0]  word[KW_CHARS];
    logic        word_ovf;
    exp_tok_t    burst[$];

    function void clear();
      phase = PH_IDLE;
      lex_start = '0;
      pos = '0;
      line_cnt = 16'd1;
      foreach (word[i]) word[i] = 8'd0;
      word_ovf = 1'b0;
    endfunction

    function void put(logic [5:0] k, logic [16:0] st, logic [16:0] en);
      exp_tok_t t;
      logic [16:0] l;
      l = (en > st) ? en - st : 17'd0;
      t.kind = k;
      t.start = (st > 17'hFFFF) ? 16'hFFFF : st[15:0];
      t.len = (l > 17'hFFFF) ? 16'hFFFF : l[15:0];
      t.line = line_cnt;
      t.last = 1'b0;
      if (burst.size() < 3) burst.insert(burst.size(), t);
    endfunction

    function bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alp(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function logic [5:0] word_kind();
      word_t w;
      if (word_ovf) return K_IDENT;
      foreach (word[i]) w[i] = word[i];
      for (int k = 0; k < N_KW; k++)
        if (w == kw_word(4'(k))) return K_KW0 + 6'(k);
      return K_IDENT;
    endfunction

    function void begin_char(logic [7:0] c, logic [15:0] cur);
      logic [5:0] k;
      phase = PH_IDLE;
      lex_start = cur;
      case (c)
        "(": k = K_LPAREN;
        ")": k = K_RPAREN;
        "{": k = K_LBRACE;
        "}": k = K_RBRACE;
        ",": k = K_COMMA;
        ".": k = K_DOT;
        "-": k = K_MINUS;
        "+": k = K_PLUS;
        ";": k = K_SEMI;
        "*": k = K_STAR;
        "!": begin phase = PH_BANG; return; end
        "=": begin phase = PH_EQUAL; return; end
        "<": begin phase = PH_LESS; return; end
        ">": begin phase = PH_GREATER; return; end
        "/": begin phase = PH_SLASH; return; end
        " ", 8'h0d, 8'h09: return;
        8'h0a: begin
          if (line_cnt != 16'hFFFF) line_cnt++;
          return;
        end
        default: begin
          if (is_dig(c)) begin phase = PH_INT; return; end
          if (is_alp(c)) begin
            foreach (word[i]) word[i] = 8'd0;
            word_ovf = 1'b0;
            word[0] = c;
            phase = PH_IDENT;
            return;
          end
          k = K_ERROR;
        end
      endcase
      put(k, {1'b0, cur}, {1'b0, cur} + 17'd1);
    endfunction

    function void close_token(logic [15:0] fin);
      logic [16:0] d;
      case (phase)
        PH_BANG, PH_EQUAL, PH_LESS, PH_GREATER:
          put(K_BANG + 6'(2 * (phase - PH_BANG)), {1'b0, lex_start},
              {1'b0, lex_start} + 17'd1);
        PH_SLASH: put(K_SLASH, {1'b0, lex_start}, {1'b0, lex_start} + 17'd1);
        PH_IDENT: put(word_kind(), {1'b0, lex_start}, {1'b0, fin});
        PH_INT, PH_FRAC: put(K_NUMBER, {1'b0, lex_start}, {1'b0, fin});
        PH_DOT: begin
          d = (fin > 0) ? {1'b0, fin} - 17'd1 : 17'd0;
          put(K_NUMBER, {1'b0, lex_start}, d);
          put(K_DOT, d, d + 17'd1);
        end
        default: ;
      endcase
      phase = PH_IDLE;
    endfunction

    // advance the model by one accepted input transaction
    function void note_input(logic [7:0] c, logic eoi);
      logic [15:0] cur;
      bit placed;
      cur = pos;
      burst.delete();
      if (eoi) begin
        close_token(cur);
        put(K_EOF, {1'b0, cur}, {1'b0, cur});
        clear();
      end else begin
        case (phase)
          PH_BANG, PH_EQUAL, PH_LESS, PH_GREATER:
            if (c == "=") begin
              put(K_BANG + 6'(2 * (phase - PH_BANG)) + 6'd1, {1'b0, lex_start},
                  {1'b0, cur} + 17'd1);
              phase = PH_IDLE;
            end else begin close_token(cur); begin_char(c, cur); end
          PH_SLASH:
            if (c == "/") phase = PH_COMMENT;
            else begin close_token(cur); begin_char(c, cur); end
          PH_COMMENT: if (c == 8'h0a) begin_char(c, cur);
          PH_IDENT:
            if (is_alp(c) || is_dig(c)) begin
              placed = 0;
              foreach (word[i])
                if (!placed && word[i] == 8'd0) begin word[i] = c; placed = 1; end
              if (!placed) word_ovf = 1'b1;
            end else begin close_token(cur); begin_char(c, cur); end
          PH_INT:
            if (c == ".") phase = PH_DOT;
            else if (!is_dig(c)) begin close_token(cur); begin_char(c, cur); end
          PH_DOT:
            if (is_dig(c)) phase = PH_FRAC;
            else begin close_token(cur); begin_char(c, cur); end
          PH_FRAC:
            if (!is_dig(c)) begin close_token(cur); begin_char(c, cur); end
          default: begin_char(c, cur);
        endcase
        if (pos != 16'hFFFF) pos++;
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending.insert(pending.size(), burst[i]);
    endfunction

    function void check_token(logic [55:0] d, logic lst);
      exp_tok_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected token, actual %h last %b", $realtime, d, lst);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[5:0] !== e.kind || d[21:6] !== e.start || d[37:22] !== e.len ||
          d[53:38] !== e.line || d[55:54] !== 2'b00 || lst !== e.last) begin
        $display("%0t: token mismatch, expected kind %0d start %0d len %0d line %0d last %b",
                 $realtime, e.kind, e.start, e.len, e.line, e.last);
        $display("%0t:   actual kind %0d start %0d len %0d line %0d last %b",
                 $realtime, d[5:0], d[21:6], d[37:22], d[53:38], lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;

  token_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_off = 0;
  bit  feeding_done = 0;
  localparam int STALL_LIMIT = 5000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lox_token_scanner_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // watchdog and transaction monitors
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_token(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (feeding_done && sb.pending.size() == 0) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // receiver: random stalls plus one long hold-off
  initial begin
    int g;
    @(posedge clk iff rst_n);
    repeat (400) @(posedge clk);
    hold_off = 1;
    out_tready <= 1'b0;
    repeat (300) @(posedge clk);
    hold_off = 0;
    forever begin
      out_tready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  bit calm;

  task automatic send_byte(logic [7:0] c, logic eoi);
    int g;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic string pick_lexeme();
    string pool[] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
      "or", "print", "return", "super", "this", "true", "var", "while", "whiles",
      "classy", "returns", "x_9", "Abc", "12", "3.75", "7.", "0.5.", "!=", "==",
      "<=", ">=", "!", "=", "<", ">", "/", "// note\n", "(", ")", "{", "}", ",",
      ".", "-", "+", ";", "*", " ", "\n", "\t", "\r", "@", "1..2", "//"};
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  initial begin
    int n;
    sb.clear();
    sb.errors = 0;
    calm = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operator, keywords, numbers, comments, odd bytes
    send_text("(){},.-+;*! != = == < <= > >= / a//c\nand class else false for fun if");
    send_text(" nil or print return super this true var while whilex ab_Z9 ");
    send_text("12 3.5 7.x 9.");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("4.");
    send_byte(8'h00, 1'b1);
    send_text("x // open comment");
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b1);
    drain();

    // random: mostly well-formed lexemes, some raw bytes
    n = 0;
    while (n < 310) begin
      if (n > 200 && n < 260) calm = 1; else calm = 0;
      if ($urandom_range(0, 9) < 7) begin
        string s;
        s = pick_lexeme();
        send_text(s);
        n += s.len();
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        n++;
      end
      if ($urandom_range(0, 39) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        n++;
      end
      if (n > 280 && n < 300) drain();
    end
    send_byte(8'h00, 1'b1);
    feeding_done = 1;
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
